// File: rtl/tacr_pkg.sv
// Package: shared types and codes for the sorted timer action queue.
package tacr_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_EXPIRE = 2'd2;

   localparam logic [1:0] KIND_ADD     = 2'd0;
   localparam logic [1:0] KIND_REMOVE  = 2'd1;
   localparam logic [1:0] KIND_FIRED   = 2'd2;
   localparam logic [1:0] KIND_COMPARE = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] delay;
      logic [7:0]  handle;
      logic [63:0] now_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        ok;
      logic [7:0]  fired_handle;
      logic [31:0] compare_value;
      logic        compare_armed;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic le;
      logic eq;
   } cmp_res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_REM,
      ST_EXP
   } state_type;

endpackage

// File: rtl/tacr_cmp.sv
// Shared compare unit: entry time against key time, entry handle against key handle.
module tacr_cmp
   import tacr_pkg::*;
(
   input  logic [63:0] entry_time,
   input  logic [7:0]  entry_handle,
   input  logic [63:0] key_time,
   input  logic [7:0]  key_handle,
   output cmp_res_type res
);

   assign res.le = (entry_time <= key_time);
   assign res.eq = (entry_handle == key_handle);

endmodule

// File: rtl/timer_action_queue_compare_rearm.sv
// Top level: sorted timer action queue with compare re-arm.
//
// Issue an item by raising start while busy is low; the item is taken at that
// clock edge and busy stays high until its work is done. Add, remove and
// expire items walk the queue one entry per cycle through a single shared
// time/handle compare unit, selected by a scan index.
// Add: steps past each entry at or before the new time and inserts there, or
// refuses when the queue is full. Remove: steps up to the matching handle or
// the end of the queue. Expire: pops each due head entry, then reports the
// compare status. An unused op code leaves busy low and gives no result.
// Each result is shown on rsp_item for one cycle with rsp_strobe high, in the
// cycle after the one that produces it; the last result of an item has
// last set. Expire gives one fired result per popped entry with a nonzero
// handle, then a compare status result. The receiver cannot stall the block;
// a new item may be issued while the final result is still on the outputs.
// Reset empties the queue and drops any item in progress; entry storage
// itself is not cleared.
module timer_action_queue_compare_rearm
   import tacr_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int CW = $clog2(DEPTH + 1);

   state_type state_ff, state_in;

   logic [63:0]   time_ff [DEPTH];
   logic [7:0]    hdl_ff  [DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [63:0]   key_ff, key_in;
   logic [7:0]    key_hdl_ff, key_hdl_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          ins_en;
   logic          del_en;
   logic [63:0]   sel_time;
   logic [7:0]    sel_hdl;
   cmp_res_type   cmp_res;
   logic          at_end;
   logic          full;
   logic          head_due;

   always_comb begin
      sel_time = '0;
      sel_hdl  = '0;
      for (int k = 0; k < DEPTH; k++) begin
         if (idx_ff == CW'(k)) begin
            sel_time = time_ff[k];
            sel_hdl  = hdl_ff[k];
         end
      end
   end

   tacr_cmp u_cmp (
      .entry_time   (sel_time),
      .entry_handle (sel_hdl),
      .key_time     (key_ff),
      .key_handle   (key_hdl_ff),
      .res          (cmp_res)
   );

   assign at_end   = (idx_ff == count_ff);
   assign full     = (count_ff == CW'(DEPTH));
   assign head_due = (count_ff != '0) && cmp_res.le;
   assign busy     = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_item.op)
                  OP_ADD:    state_in = ST_ADD;
                  OP_REMOVE: state_in = ST_REM;
                  OP_EXPIRE: state_in = ST_EXP;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD: begin
            if (full || at_end || !cmp_res.le) state_in = ST_IDLE;
         end
         ST_REM: begin
            if (at_end || cmp_res.eq) state_in = ST_IDLE;
         end
         ST_EXP: begin
            if (!head_due) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      key_in       = key_ff;
      key_hdl_in   = key_hdl_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      ins_en       = 1'b0;
      del_en       = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in     = req_item.now_time
                          + ((req_item.op == OP_ADD) ? {32'b0, req_item.delay} : 64'b0);
               key_hdl_in = req_item.handle;
               idx_in     = '0;
            end
         end
         ST_ADD: begin
            rsp_in.kind = KIND_ADD;
            rsp_in.last = 1'b1;
            if (full) begin
               rsp_valid_in = 1'b1;
            end else if (at_end || !cmp_res.le) begin
               ins_en       = 1'b1;
               count_in     = count_ff + CW'(1);
               rsp_valid_in = 1'b1;
               rsp_in.ok    = 1'b1;
               if (idx_ff == '0) begin
                  rsp_in.compare_value = key_ff[31:0];
                  rsp_in.compare_armed = 1'b1;
               end
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_REM: begin
            rsp_in.kind = KIND_REMOVE;
            rsp_in.last = 1'b1;
            if (at_end) begin
               rsp_valid_in = 1'b1;
            end else if (cmp_res.eq) begin
               del_en       = 1'b1;
               count_in     = count_ff - CW'(1);
               rsp_valid_in = 1'b1;
               rsp_in.ok    = 1'b1;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_EXP: begin
            rsp_in.ok = 1'b1;
            if (head_due) begin
               del_en              = 1'b1;
               count_in            = count_ff - CW'(1);
               rsp_valid_in        = (sel_hdl != '0);
               rsp_in.kind         = KIND_FIRED;
               rsp_in.fired_handle = sel_hdl;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in.kind  = KIND_COMPARE;
               rsp_in.last  = 1'b1;
               if (count_ff != '0) begin
                  rsp_in.compare_value = sel_time[31:0];
                  rsp_in.compare_armed = 1'b1;
               end
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      key_hdl_ff <= key_hdl_in;
      rsp_ff     <= rsp_in;
      if (ins_en) begin
         for (int k = 0; k < DEPTH; k++) begin
            if (CW'(k) == idx_ff) begin
               time_ff[k] <= key_ff;
               hdl_ff[k]  <= key_hdl_ff;
            end
         end
         for (int k = 1; k < DEPTH; k++) begin
            if (CW'(k) > idx_ff && CW'(k) <= count_ff) begin
               time_ff[k] <= time_ff[k-1];
               hdl_ff[k]  <= hdl_ff[k-1];
            end
         end
      end
      if (del_en) begin
         for (int k = 0; k < DEPTH - 1; k++) begin
            if (CW'(k) >= idx_ff && CW'(k + 1) < count_ff) begin
               time_ff[k] <= time_ff[k+1];
               hdl_ff[k]  <= hdl_ff[k+1];
            end
         end
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CW'(1))
                     || (count_ff == $past(count_ff) - CW'(1)))
      else $error("queue count moved by more than one");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_item.kind == KIND_ADD || rsp_item.kind == KIND_REMOVE)
      |-> rsp_item.last)
      else $error("add or remove result without last");

   a_fired_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.kind == KIND_FIRED |-> rsp_item.fired_handle != 8'd0
                                                  && !rsp_item.last)
      else $error("fired result with no callback or marked last");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |=> !rsp_strobe)
      else $error("result produced from idle");
`endif

endmodule

// File: dv/testbench.sv
// Testbench: random and directed items against a scoreboard for the sorted timer action queue.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tacr_pkg::*;

   localparam int         QUEUE_DEPTH  = 4;
   localparam int         RANDOM_ITEMS = 420;
   localparam int         QUIET_LIMIT  = 500;
   localparam int         PRINT_CAP    = 100;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   class timer_queue_scoreboard;
      logic [63:0] entry_time [QUEUE_DEPTH];
      logic [7:0]  entry_handle [QUEUE_DEPTH];
      int          entry_total;
      rsp_type     awaited_results [$];
      int          error_count;

      function void push_result(logic [1:0] kind, logic ok, logic [7:0] fired,
                                logic [31:0] compare, logic armed, logic last);
         rsp_type r;
         r.kind          = kind;
         r.ok            = ok;
         r.fired_handle  = fired;
         r.compare_value = compare;
         r.compare_armed = armed;
         r.last          = last;
         awaited_results.push_back(r);
      endfunction

      function void drop_entry(int pos);
         for (int i = pos; i + 1 < entry_total; i++) begin
            entry_time[i]   = entry_time[i + 1];
            entry_handle[i] = entry_handle[i + 1];
         end
         entry_total--;
      endfunction

      function void apply_item(req_type item);
         logic [63:0] trigger;
         logic [7:0]  head_handle;
         int          pos;
         case (item.op)
            OP_ADD: begin
               trigger = item.now_time + {32'd0, item.delay};
               if (entry_total >= QUEUE_DEPTH) begin
                  push_result(KIND_ADD, 1'b0, 8'd0, 32'd0, 1'b0, 1'b1);
               end else begin
                  pos = 0;
                  while (pos < entry_total && entry_time[pos] <= trigger) pos++;
                  for (int i = entry_total; i > pos; i--) begin
                     entry_time[i]   = entry_time[i - 1];
                     entry_handle[i] = entry_handle[i - 1];
                  end
                  entry_time[pos]   = trigger;
                  entry_handle[pos] = item.handle;
                  entry_total++;
                  if (pos == 0) begin
                     push_result(KIND_ADD, 1'b1, 8'd0, trigger[31:0], 1'b1, 1'b1);
                  end else begin
                     push_result(KIND_ADD, 1'b1, 8'd0, 32'd0, 1'b0, 1'b1);
                  end
               end
            end
            OP_REMOVE: begin
               pos = 0;
               while (pos < entry_total && entry_handle[pos] != item.handle) pos++;
               if (pos >= entry_total) begin
                  push_result(KIND_REMOVE, 1'b0, 8'd0, 32'd0, 1'b0, 1'b1);
               end else begin
                  drop_entry(pos);
                  push_result(KIND_REMOVE, 1'b1, 8'd0, 32'd0, 1'b0, 1'b1);
               end
            end
            OP_EXPIRE: begin
               while (entry_total > 0 && entry_time[0] <= item.now_time) begin
                  head_handle = entry_handle[0];
                  drop_entry(0);
                  if (head_handle != 8'd0) begin
                     push_result(KIND_FIRED, 1'b1, head_handle, 32'd0, 1'b0, 1'b0);
                  end
               end
               if (entry_total > 0) begin
                  push_result(KIND_COMPARE, 1'b1, 8'd0, entry_time[0][31:0], 1'b1, 1'b1);
               end else begin
                  push_result(KIND_COMPARE, 1'b1, 8'd0, 32'd0, 1'b0, 1'b1);
               end
            end
            default: begin
            end
         endcase
      endfunction

      task report(string what, logic [63:0] want, logic [63:0] got);
         error_count++;
         if (error_count <= PRINT_CAP) begin
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
         end
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (awaited_results.size() == 0) begin
            report("result with none awaited", 64'd0, 64'(got));
            return;
         end
         want = awaited_results.pop_front();
         if (got.kind !== want.kind) report("kind", 64'(want.kind), 64'(got.kind));
         if (got.ok !== want.ok) report("ok", 64'(want.ok), 64'(got.ok));
         if (got.fired_handle !== want.fired_handle) begin
            report("fired_handle", 64'(want.fired_handle), 64'(got.fired_handle));
         end
         if (got.compare_value !== want.compare_value) begin
            report("compare_value", 64'(want.compare_value), 64'(got.compare_value));
         end
         if (got.compare_armed !== want.compare_armed) begin
            report("compare_armed", 64'(want.compare_armed), 64'(got.compare_armed));
         end
         if (got.last !== want.last) report("last", 64'(want.last), 64'(got.last));
      endtask
   endclass

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   logic    busy;
   req_type req_item   = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;
   int      quiet_cycles = 0;

   timer_queue_scoreboard sb = new;

   timer_action_queue_compare_rearm #(.DEPTH(QUEUE_DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_item);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(logic [1:0] op, logic [31:0] delay, logic [7:0] handle,
                            logic [63:0] now_time);
      req_type item;
      item.op       = op;
      item.delay    = delay;
      item.handle   = handle;
      item.now_time = now_time;
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      sb.apply_item(item);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (sb.awaited_results.size() != 0);
   endtask

   initial begin
      logic [63:0] base;
      logic [1:0]  op;
      logic [31:0] delay;
      logic [7:0]  handle;
      logic [63:0] now_time;
      int          burst_left;
      int          pause;
      int          pick;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_EXPIRE, 32'd0, 8'h00, 64'd0);
      send_item(OP_REMOVE, 32'd0, 8'h00, 64'd0);
      send_item(OP_ADD, 32'd0, 8'h00, 64'd0);
      send_item(OP_ADD, 32'd5, 8'hFF, 64'd0);
      send_item(OP_ADD, 32'd5, 8'h02, 64'd0);
      send_item(OP_ADD, 32'hFFFF_FFFF, 8'h03, 64'd0);
      send_item(OP_ADD, 32'd1, 8'h04, 64'd0);
      send_item(OP_REMOVE, 32'd0, 8'h02, 64'd0);
      send_item(OP_REMOVE, 32'd0, 8'h09, 64'd0);
      send_item(OP_EXPIRE, 32'd0, 8'h00, 64'd5);
      send_item(OP_UNUSED, $urandom, 8'($urandom), {$urandom, $urandom});
      send_item(OP_ADD, 32'h20, 8'h05, 64'hFFFF_FFFF_FFFF_FFF0);
      send_item(OP_ADD, 32'd0, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(OP_REMOVE, 32'd0, 8'h00, 64'd0);
      send_item(OP_REMOVE, 32'd0, 8'h05, 64'd0);
      send_item(OP_EXPIRE, $urandom, 8'hAA, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(OP_ADD, 32'd40, 8'h81, 64'd100);
      send_item(OP_ADD, 32'd30, 8'h42, 64'd100);
      send_item(OP_ADD, 32'd20, 8'h24, 64'd100);
      send_item(OP_ADD, 32'd10, 8'h18, 64'd100);
      send_item(OP_EXPIRE, 32'd0, 8'h00, 64'd140);
      send_item(OP_ADD, 32'd7, 8'h11, 64'h0123_4567_89AB_CDEF);
      send_item(OP_EXPIRE, 32'd0, 8'h00, 64'h0123_4567_89AB_CDEF);
      drain_results();

      base       = 64'd1000;
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) drain_results();
         if (burst_left == 0) begin
            pause      = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(1, 10);
            if (pause != 0) begin
               start <= 1'b0;
               repeat (pause) @(posedge clock);
            end
         end
         burst_left--;

         pick = $urandom_range(0, 19);
         if (pick == 0) base = 64'hFFFF_FFFF_FFFF_FF00 + $urandom_range(0, 255);
         else if (pick == 1) base = {$urandom, $urandom};
         else base = base + $urandom_range(0, 12);

         pick = $urandom_range(0, 99);
         if (pick < 45) op = OP_ADD;
         else if (pick < 65) op = OP_REMOVE;
         else if (pick < 95) op = OP_EXPIRE;
         else op = OP_UNUSED;
         delay    = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 40) : $urandom;
         handle   = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 6))
                                                 : 8'($urandom_range(0, 255));
         now_time = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : base;
         send_item(op, delay, handle, now_time);
      end

      start <= 1'b0;
      while (sb.awaited_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.error_count == 0 && sb.awaited_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
